// File: rtl/collider_pair_overlap_test_defines.svh
// Assertion macros used by the top level of the collider pair overlap test RTL.
`ifndef COLLIDER_PAIR_OVERLAP_TEST_DEFINES_SVH
`define COLLIDER_PAIR_OVERLAP_TEST_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define CPOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CPOT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/cpot_pkg.sv
// Package with the kind codes and the stage control type of the overlap test.
package cpot_pkg;

    localparam int KIND_BITS = 2;
    localparam logic [KIND_BITS-1:0] KIND_CIRCLE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_BOX    = 2'd1;

    localparam int TUSER_BITS  = 2 * KIND_BITS;
    localparam int OUT_TDATA_W = 8;

    // sq: the decision waits for the squared compare.
    // strict: the squared compare is strict (circle pairs).
    // hit: the decision when no squared compare is needed.
    typedef struct packed {
        logic sq;
        logic strict;
        logic hit;
    } ctl_t;

endpackage

// File: rtl/collider_pair_overlap_test.sv
// Top level of the 2D collider pair overlap test.
// Each item is one pair of colliders (circle, box or another kind) and yields one item that
// says whether the two overlap. While the result side does not stall, the block takes one
// item in every clock cycle. Its work is split over four register stages: pair
// classification with the doubled distances, axis rejects with operand selection, three
// COORD_BITS by COORD_BITS squarers, and the squared compare that feeds the output register.
// Circle pairs overlap when the squared center distance is strictly below the squared radius
// sum. Box pairs overlap when their extents meet on both axes, and touching edges count. A box
// and a circle are tested from the box center at position plus half size; the corner case
// accepts a squared distance equal to the squared radius. A pair that holds any other kind
// never overlaps. Tests with a box work on doubled values, so nothing is rounded. A stall on
// the result side backs up stage by stage, and the input side keeps accepting until every
// stage is occupied. Positions are signed and sizes unsigned, both with eight fraction bits.
`include "collider_pair_overlap_test_defines.svh"

module collider_pair_overlap_test
    import cpot_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // From bit 0: pos_x_a, pos_y_a, size_w_a, size_h_a, pos_x_b, pos_y_b, size_w_b,
    // size_h_b, then zero padding to a whole byte.
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    // From bit 0: kind_a, kind_b.
    input  logic [TUSER_BITS-1:0]   s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // From bit 0: overlap, then zero padding.
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int W     = COORD_BITS;
    localparam int OFF_XA = 0;
    localparam int OFF_YA = OFF_XA + W;
    localparam int OFF_WA = OFF_YA + W;
    localparam int OFF_HA = OFF_WA + W - 1;
    localparam int OFF_XB = OFF_HA + W - 1;
    localparam int OFF_YB = OFF_XB + W;
    localparam int OFF_WB = OFF_YB + W;
    localparam int OFF_HB = OFF_WB + W - 1;

    // Stage 1 to stage 2.
    logic                 v1, r1;
    logic signed [W+2:0]  dx1, dy1;
    logic [W-2:0]         ew1, eh1;
    logic [W-1:0]         rad1;
    ctl_t                 ctl1;

    // Stage 2 to stage 3.
    logic                 v2, r2;
    logic [W-1:0]         opx2, opy2, opr2;
    ctl_t                 ctl2;

    // Stage 3 to stage 4.
    logic                 v3, r3;
    logic [2*W-1:0]       sqx3, sqy3, sqr3;
    ctl_t                 ctl3;

    logic                 overlap;

    cpot_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .kind_a    (s_axis_tuser[KIND_BITS-1:0]),
        .pos_x_a   (signed'(s_axis_tdata[OFF_XA +: W])),
        .pos_y_a   (signed'(s_axis_tdata[OFF_YA +: W])),
        .size_w_a  (s_axis_tdata[OFF_WA +: W-1]),
        .size_h_a  (s_axis_tdata[OFF_HA +: W-1]),
        .kind_b    (s_axis_tuser[KIND_BITS +: KIND_BITS]),
        .pos_x_b   (signed'(s_axis_tdata[OFF_XB +: W])),
        .pos_y_b   (signed'(s_axis_tdata[OFF_YB +: W])),
        .size_w_b  (s_axis_tdata[OFF_WB +: W-1]),
        .size_h_b  (s_axis_tdata[OFF_HB +: W-1]),
        .out_valid (v1),
        .out_ready (r1),
        .dx        (dx1),
        .dy        (dy1),
        .ext_w     (ew1),
        .ext_h     (eh1),
        .rad       (rad1),
        .ctl       (ctl1)
    );

    cpot_classify #(.W(W)) u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .dx        (dx1),
        .dy        (dy1),
        .ext_w     (ew1),
        .ext_h     (eh1),
        .rad       (rad1),
        .ctl_in    (ctl1),
        .out_valid (v2),
        .out_ready (r2),
        .op_x      (opx2),
        .op_y      (opy2),
        .op_r      (opr2),
        .ctl_out   (ctl2)
    );

    cpot_square #(.W(W)) u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .op_x      (opx2),
        .op_y      (opy2),
        .op_r      (opr2),
        .ctl_in    (ctl2),
        .out_valid (v3),
        .out_ready (r3),
        .sq_x      (sqx3),
        .sq_y      (sqy3),
        .sq_r      (sqr3),
        .ctl_out   (ctl3)
    );

    cpot_decide #(.W(W)) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .sq_x      (sqx3),
        .sq_y      (sqy3),
        .sq_r      (sqr3),
        .ctl_in    (ctl3),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .overlap   (overlap)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, overlap};

    // A free-running result side never stalls the input side.
    `CPOT_ASSERT(a_ready_chain, m_axis_tready |-> s_axis_tready, "input stalled while output drains")
    // With the result side ready while the item moves through the stages, an accepted item reaches the output.
    `CPOT_ASSERT(a_latency, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid, "accepted item did not arrive at the output")
    // Reset empties the output register.
    `CPOT_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid, "output valid after reset")

endmodule

// File: rtl/cpot_front.sv
// First stage: pair classification, doubled distances and the box pair test.
module cpot_front
    import cpot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_BITS-1:0]  kind_a,
    input  logic signed [W-1:0]   pos_x_a,
    input  logic signed [W-1:0]   pos_y_a,
    input  logic [W-2:0]          size_w_a,
    input  logic [W-2:0]          size_h_a,
    input  logic [KIND_BITS-1:0]  kind_b,
    input  logic signed [W-1:0]   pos_x_b,
    input  logic signed [W-1:0]   pos_y_b,
    input  logic [W-2:0]          size_w_b,
    input  logic [W-2:0]          size_h_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [W+2:0]   dx,
    output logic signed [W+2:0]   dy,
    output logic [W-2:0]          ext_w,
    output logic [W-2:0]          ext_h,
    output logic [W-1:0]          rad,
    output ctl_t                  ctl
);

    localparam int EW = W + 3;

    logic                 valid_reg;
    logic signed [EW-1:0] dx_reg, dx_next;
    logic signed [EW-1:0] dy_reg, dy_next;
    logic [W-2:0]         ext_w_reg, ext_w_next;
    logic [W-2:0]         ext_h_reg, ext_h_next;
    logic [W-1:0]         rad_reg, rad_next;
    ctl_t                 ctl_reg, ctl_next;

    logic signed [EW-1:0] xa_e, ya_e, xb_e, yb_e;
    logic signed [EW-1:0] wa_e, ha_e, wb_e, hb_e;
    logic signed [EW-1:0] ddx, ddy, bx2, by2, cx2, cy2, bw_e, bh_e;
    logic [W-2:0]         box_w, box_h, circ_r;
    logic                 is_cc, is_bb, is_bc, swap, bb_reject;

    always_comb begin
        xa_e = EW'(pos_x_a);
        ya_e = EW'(pos_y_a);
        xb_e = EW'(pos_x_b);
        yb_e = EW'(pos_y_b);
        wa_e = signed'(EW'(size_w_a));
        ha_e = signed'(EW'(size_h_a));
        wb_e = signed'(EW'(size_w_b));
        hb_e = signed'(EW'(size_h_b));

        is_cc = (kind_a == KIND_CIRCLE) && (kind_b == KIND_CIRCLE);
        is_bb = (kind_a == KIND_BOX) && (kind_b == KIND_BOX);
        is_bc = ((kind_a == KIND_BOX) && (kind_b == KIND_CIRCLE)) ||
                ((kind_a == KIND_CIRCLE) && (kind_b == KIND_BOX));
        swap  = (kind_a == KIND_CIRCLE);

        // Box pair: compare doubled edges, touching counts as overlap.
        ddx = (xa_e + xa_e) - (xb_e + xb_e);
        ddy = (ya_e + ya_e) - (yb_e + yb_e);
        bb_reject = (ddx + wa_e + wb_e < 0) || (ddx - wa_e - wb_e > 0) ||
                    (ddy + ha_e + hb_e < 0) || (ddy - ha_e - hb_e > 0);

        // Box against circle, with the box always taken as the first role.
        box_w  = swap ? size_w_b : size_w_a;
        box_h  = swap ? size_h_b : size_h_a;
        circ_r = swap ? size_w_a : size_w_b;
        bw_e   = swap ? wb_e : wa_e;
        bh_e   = swap ? hb_e : ha_e;
        bx2    = swap ? (xb_e + xb_e) : (xa_e + xa_e);
        by2    = swap ? (yb_e + yb_e) : (ya_e + ya_e);
        cx2    = swap ? (xa_e + xa_e) : (xb_e + xb_e);
        cy2    = swap ? (ya_e + ya_e) : (yb_e + yb_e);

        if (is_cc) begin
            dx_next    = xa_e - xb_e;
            dy_next    = ya_e - yb_e;
            ext_w_next = '0;
            ext_h_next = '0;
            rad_next   = W'(size_w_a) + W'(size_w_b);
        end else begin
            dx_next    = cx2 - bx2 - bw_e;
            dy_next    = cy2 - by2 - bh_e;
            ext_w_next = box_w;
            ext_h_next = box_h;
            rad_next   = {circ_r, 1'b0};
        end

        ctl_next.sq     = is_cc || is_bc;
        ctl_next.strict = is_cc;
        ctl_next.hit    = is_bb && !bb_reject;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            ext_w_reg <= ext_w_next;
            ext_h_reg <= ext_h_next;
            rad_reg   <= rad_next;
            ctl_reg   <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign ext_w     = ext_w_reg;
    assign ext_h     = ext_h_reg;
    assign rad       = rad_reg;
    assign ctl       = ctl_reg;

endmodule

// File: rtl/cpot_classify.sv
// Second stage: magnitudes, axis rejects and the operands for squaring.
module cpot_classify
    import cpot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W+2:0]  dx,
    input  logic signed [W+2:0]  dy,
    input  logic [W-2:0]         ext_w,
    input  logic [W-2:0]         ext_h,
    input  logic [W-1:0]         rad,
    input  ctl_t                 ctl_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [W-1:0]         op_x,
    output logic [W-1:0]         op_y,
    output logic [W-1:0]         op_r,
    output ctl_t                 ctl_out
);

    localparam int MW = W + 2;

    logic          valid_reg;
    logic [W-1:0]  op_x_reg, op_x_next;
    logic [W-1:0]  op_y_reg, op_y_next;
    logic [W-1:0]  op_r_reg;
    ctl_t          ctl_reg, ctl_next;

    logic signed [W+2:0] neg_x, neg_y;
    logic [MW-1:0]       ax, ay, lim_x, lim_y;
    logic                is_bc, reject, in_box;

    always_comb begin
        neg_x = -dx;
        neg_y = -dy;
        ax    = dx[W+2] ? neg_x[MW-1:0] : dx[MW-1:0];
        ay    = dy[W+2] ? neg_y[MW-1:0] : dy[MW-1:0];
        lim_x = MW'(ext_w) + MW'(rad);
        lim_y = MW'(ext_h) + MW'(rad);

        is_bc  = ctl_in.sq && !ctl_in.strict;
        reject = (ax > lim_x) || (ay > lim_y);
        in_box = (ax <= MW'(ext_w)) || (ay <= MW'(ext_h));

        // The extents are zero for circle pairs, so one subtract serves both.
        op_x_next = ax[W-1:0] - W'(ext_w);
        op_y_next = ay[W-1:0] - W'(ext_h);

        ctl_next = ctl_in;
        if (is_bc && reject) begin
            ctl_next.sq  = 1'b0;
            ctl_next.hit = 1'b0;
        end else if (is_bc && in_box) begin
            ctl_next.sq  = 1'b0;
            ctl_next.hit = 1'b1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_x_reg <= op_x_next;
            op_y_reg <= op_y_next;
            op_r_reg <= rad;
            ctl_reg  <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign op_x      = op_x_reg;
    assign op_y      = op_y_reg;
    assign op_r      = op_r_reg;
    assign ctl_out   = ctl_reg;

endmodule

// File: rtl/cpot_square.sv
// Third stage: the three squarers.
module cpot_square
    import cpot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [W-1:0]      op_x,
    input  logic [W-1:0]      op_y,
    input  logic [W-1:0]      op_r,
    input  ctl_t              ctl_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2*W-1:0]    sq_x,
    output logic [2*W-1:0]    sq_y,
    output logic [2*W-1:0]    sq_r,
    output ctl_t              ctl_out
);

    localparam int PW = 2 * W;

    logic          valid_reg;
    logic [PW-1:0] sq_x_reg, sq_x_next;
    logic [PW-1:0] sq_y_reg, sq_y_next;
    logic [PW-1:0] sq_r_reg, sq_r_next;
    ctl_t          ctl_reg;

    always_comb begin
        sq_x_next = PW'(op_x) * PW'(op_x);
        sq_y_next = PW'(op_y) * PW'(op_y);
        sq_r_next = PW'(op_r) * PW'(op_r);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
            sq_r_reg <= sq_r_next;
            ctl_reg  <= ctl_in;
        end
    end

    assign out_valid = valid_reg;
    assign sq_x      = sq_x_reg;
    assign sq_y      = sq_y_reg;
    assign sq_r      = sq_r_reg;
    assign ctl_out   = ctl_reg;

endmodule

// File: rtl/cpot_decide.sv
// Last stage: squared distance compare and the output register.
module cpot_decide
    import cpot_pkg::*;
#(
    parameter int W = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2*W-1:0]    sq_x,
    input  logic [2*W-1:0]    sq_y,
    input  logic [2*W-1:0]    sq_r,
    input  ctl_t              ctl_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              overlap
);

    localparam int SW = 2 * W + 1;

    logic          valid_reg;
    logic          overlap_reg, overlap_next;
    logic [SW-1:0] dist_sq, lim;

    always_comb begin
        dist_sq = SW'(sq_x) + SW'(sq_y);
        lim     = SW'(sq_r);
        if (!ctl_in.sq) begin
            overlap_next = ctl_in.hit;
        end else if (ctl_in.strict) begin
            overlap_next = dist_sq < lim;
        end else begin
            overlap_next = dist_sq <= lim;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            overlap_reg <= overlap_next;
        end
    end

    assign out_valid = valid_reg;
    assign overlap   = overlap_reg;

endmodule

// File: dv/collider_pair_overlap_checker.sv
// Checker for the collider pair overlap test: predicts each overlap item and compares it.
`timescale 1ns / 1ps

module collider_pair_overlap_checker
    import cpot_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    // From bit 0: pos_x_a, pos_y_a, size_w_a, size_h_a, pos_x_b, pos_y_b, size_w_b,
    // size_h_b, then zero padding to a whole byte.
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    // From bit 0: kind_a, kind_b.
    input  logic [TUSER_BITS-1:0]   s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // From bit 0: overlap, then zero padding.
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output int                      pairs_in,
    output int                      results_out,
    output int                      overlaps_seen,
    output int                      fail_count
);

    localparam int TDATA_W = ((8*COORD_BITS-4+7)/8)*8;
    localparam int OFF_XA  = 0;
    localparam int OFF_YA  = COORD_BITS;
    localparam int OFF_WA  = 2*COORD_BITS;
    localparam int OFF_HA  = 3*COORD_BITS - 1;
    localparam int OFF_XB  = 4*COORD_BITS - 2;
    localparam int OFF_YB  = 5*COORD_BITS - 2;
    localparam int OFF_WB  = 6*COORD_BITS - 2;
    localparam int OFF_HB  = 7*COORD_BITS - 3;

    bit expected_overlaps[$];

    // Box corner at (bx, by), circle center at (cx, cy); all distances are doubled.
    function automatic bit box_meets_circle(input longint bx, input longint by,
                                            input longint w, input longint h,
                                            input longint cx, input longint cy,
                                            input longint r);
        longint dx, dy, r2, ex, ey;
        dx = 2*cx - (2*bx + w);
        dy = 2*cy - (2*by + h);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        r2 = 2*r;
        if (dx > w + r2 || dy > h + r2) return 1'b0;
        if (dx <= w || dy <= h) return 1'b1;
        ex = dx - w;
        ey = dy - h;
        return (ex*ex + ey*ey) <= r2*r2;
    endfunction

    function automatic bit predict_overlap(input logic [TUSER_BITS-1:0] kinds,
                                           input logic [TDATA_W-1:0] d);
        logic [KIND_BITS-1:0] ka, kb;
        longint xa, ya, wa, ha, xb, yb, wb, hb, dx, dy, rsum;
        ka = kinds[KIND_BITS-1:0];
        kb = kinds[TUSER_BITS-1:KIND_BITS];
        xa = longint'($signed(d[OFF_XA +: COORD_BITS]));
        ya = longint'($signed(d[OFF_YA +: COORD_BITS]));
        wa = longint'(d[OFF_WA +: COORD_BITS-1]);
        ha = longint'(d[OFF_HA +: COORD_BITS-1]);
        xb = longint'($signed(d[OFF_XB +: COORD_BITS]));
        yb = longint'($signed(d[OFF_YB +: COORD_BITS]));
        wb = longint'(d[OFF_WB +: COORD_BITS-1]);
        hb = longint'(d[OFF_HB +: COORD_BITS-1]);
        if (ka == KIND_CIRCLE && kb == KIND_CIRCLE) begin
            dx = xa - xb;
            dy = ya - yb;
            rsum = wa + wb;
            return (dx*dx + dy*dy) < rsum*rsum;
        end
        if (ka == KIND_BOX && kb == KIND_BOX)
            return !(2*xa + wa < 2*xb - wb || 2*xa - wa > 2*xb + wb ||
                     2*ya + ha < 2*yb - hb || 2*ya - ha > 2*yb + hb);
        if (ka == KIND_BOX && kb == KIND_CIRCLE)
            return box_meets_circle(xa, ya, wa, ha, xb, yb, wb);
        if (ka == KIND_CIRCLE && kb == KIND_BOX)
            return box_meets_circle(xb, yb, wb, hb, xa, ya, wa);
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        bit want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            pairs_in      <= 0;
            results_out   <= 0;
            overlaps_seen <= 0;
            fail_count    <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_overlaps = {expected_overlaps,
                                     predict_overlap(s_axis_tuser, s_axis_tdata)};
                pairs_in <= pairs_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_out <= results_out + 1;
                if (m_axis_tdata[0] === 1'b1)
                    overlaps_seen <= overlaps_seen + 1;
                if (expected_overlaps.size() == 0) begin
                    $error("unexpected result item: overlap actual %0b", m_axis_tdata[0]);
                    errs++;
                end else begin
                    want = expected_overlaps.pop_front();
                    if (m_axis_tdata[0] !== want) begin
                        $error("overlap: expected %0b, actual %0b", want, m_axis_tdata[0]);
                        errs++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:1] !== '0) begin
                        $error("padding: expected %0h, actual %0h", 0,
                               m_axis_tdata[OUT_TDATA_W-1:1]);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// File: dv/collider_pair_overlap_test_tb.sv
// Testbench top for the collider pair overlap test: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module collider_pair_overlap_test_tb;
    import cpot_pkg::*;

    localparam int CB      = 24;
    localparam int TDATA_W = ((8*CB-4+7)/8)*8;

    // Kinds the block treats as never colliding. Only the stimulus needs them.
    localparam logic [KIND_BITS-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

    localparam int RANDOM_PAIRS = 850;

    // Field extremes: signed Q15.8 positions and unsigned Q15.8 sizes.
    localparam logic signed [CB-1:0] POS_MAX  = 24'sh7FFFFF;
    localparam logic signed [CB-1:0] POS_MIN  = 24'sh800000;
    localparam logic [CB-2:0]        SIZE_MAX = 23'h7FFFFF;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [TUSER_BITS-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int pairs_in, results_out, overlaps_seen, fail_count;
    int held_off_cycles = 0;
    int burst_left      = 1;

    collider_pair_overlap_test #(.COORD_BITS(CB)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    collider_pair_overlap_checker #(.COORD_BITS(CB)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .pairs_in      (pairs_in),
        .results_out   (results_out),
        .overlaps_seen (overlaps_seen),
        .fail_count    (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A correct run finishes well before this timeout.
    initial begin
        #2_000_000;
        $display("collider_pair_overlap_test_tb: FAIL");
        $finish;
    end

    // Offers one pair of colliders and holds it until the block takes it. It is entered and
    // left at a falling edge. The sender works in bursts: when a burst runs out, it usually
    // drops tvalid for a random gap, and sometimes it goes straight on, so that there are
    // stretches with no gaps at all.
    task automatic send_pair(input logic [1:0] ka, input logic signed [CB-1:0] xa,
                             input logic signed [CB-1:0] ya, input logic [CB-2:0] wa,
                             input logic [CB-2:0] ha, input logic [1:0] kb,
                             input logic signed [CB-1:0] xb, input logic signed [CB-1:0] yb,
                             input logic [CB-2:0] wb, input logic [CB-2:0] hb);
        s_axis_tuser  = {kb, ka};
        s_axis_tdata  = TDATA_W'({hb, wb, yb, xb, ha, wa, ya, xa});
        s_axis_tvalid = 1'b1;
        // tready is sampled at the rising edge, before the block updates its registers.
        do begin
            @(posedge aclk);
            if (!s_axis_tready)
                held_off_cycles++;
        end while (!s_axis_tready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
        end
    endtask

    // Mostly circles and boxes, with the two never-colliding kinds now and then.
    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)  return KIND_CIRCLE;
        if (r < 18) return KIND_BOX;
        if (r == 18) return KIND_OTHER;
        return KIND_SPARE;
    endfunction

    // Sizes are mostly small so that pairs land near each other; a few use the full range.
    function automatic logic [CB-2:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return (CB-1)'($urandom_range(0, 4095));
        if (r < 19) return (CB-1)'($urandom_range(0, 262143));
        return (CB-1)'($urandom_range(0, SIZE_MAX));
    endfunction

    // The receiver changes its stall pattern at random intervals: always ready, random,
    // mostly ready, or mostly stalled. Twice in the run it holds off for a long stretch while
    // the sender keeps offering, so the pipeline fills and the input side backs up.
    initial begin
        int  span, mode;
        bit  early_hold_done, late_hold_done;
        early_hold_done = 1'b0;
        late_hold_done  = 1'b0;
        forever begin
            if ((!early_hold_done && pairs_in >= 60) || (!late_hold_done && pairs_in >= 500)) begin
                if (pairs_in >= 500)
                    late_hold_done = 1'b1;
                early_hold_done = 1'b1;
                @(negedge aclk);
                m_axis_tready = 1'b0;
                repeat (120) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    2:       m_axis_tready = ($urandom_range(0, 7) != 0);
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [1:0]             ka, kb;
        logic signed [CB-1:0]   xa, ya, xb, yb;
        logic [CB-2:0]          wa, ha, wb, hb;
        int                     style, o, m, cx, cy, r, span;
        bit                     flip;

        // Synchronous reset, asserted from the start and then released for good.
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed pairs. One unit in Q15.8 is 256.
        // Two circles exactly touching do not overlap; one step closer they do.
        send_pair(KIND_CIRCLE, 0, 0, 256, 0, KIND_CIRCLE, 512, 0, 256, 0);
        send_pair(KIND_CIRCLE, 0, 0, 256, 0, KIND_CIRCLE, 511, 0, 256, 0);
        // Circles at opposite corners of the coordinate range with the largest radii.
        send_pair(KIND_CIRCLE, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                  KIND_CIRCLE, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
        // Along one axis the radius sum falls one step short of the distance.
        send_pair(KIND_CIRCLE, POS_MIN, 0, SIZE_MAX, SIZE_MAX,
                  KIND_CIRCLE, POS_MAX, 0, SIZE_MAX, SIZE_MAX);
        // Coincident circles of zero radius: the strict compare says no overlap.
        send_pair(KIND_CIRCLE, 0, 0, 0, 0, KIND_CIRCLE, 0, 0, 0, 0);
        // Boxes with touching edges overlap; one step apart or offset in y they do not.
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_BOX, 512, 0, 512, 512);
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_BOX, 513, 0, 512, 512);
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_BOX, 0, -513, 512, 512);
        // Largest boxes at opposite extremes, and zero-size boxes on the same point.
        send_pair(KIND_BOX, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                  KIND_BOX, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
        send_pair(KIND_BOX, POS_MIN, POS_MIN, 0, 0, KIND_BOX, POS_MIN, POS_MIN, 0, 0);
        // Box corner at (512, 512), circle center on a 300-400-500 triangle from it: the
        // corner distance equals the radius and counts as overlap; one step less does not.
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_CIRCLE, 812, 912, 500, 0);
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_CIRCLE, 812, 912, 499, 0);
        // The same pair with the circle first, so the roles are swapped.
        send_pair(KIND_CIRCLE, 812, 912, 500, 0, KIND_BOX, 0, 0, 512, 512);
        // Axis reject on x, then a circle just reaching the box side.
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_CIRCLE, 1012, 256, 250, 0);
        send_pair(KIND_BOX, 0, 0, 512, 512, KIND_CIRCLE, 1012, 256, 500, 0);
        // Zero-size box and zero-radius circle on the same point.
        send_pair(KIND_BOX, 0, 0, 0, 0, KIND_CIRCLE, 0, 0, 0, 0);
        // Box and circle at the extremes of every field, in both orders.
        send_pair(KIND_BOX, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX,
                  KIND_CIRCLE, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX);
        send_pair(KIND_CIRCLE, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX,
                  KIND_BOX, POS_MIN, POS_MAX, SIZE_MAX, SIZE_MAX);
        // Any pair holding another kind never overlaps, even when the shapes coincide.
        send_pair(KIND_OTHER, 0, 0, 256, 256, KIND_CIRCLE, 0, 0, 256, 256);
        send_pair(KIND_CIRCLE, 0, 0, 256, 256, KIND_OTHER, 0, 0, 256, 256);
        send_pair(KIND_OTHER, 0, 0, 256, 256, KIND_OTHER, 0, 0, 256, 256);
        send_pair(KIND_SPARE, 0, 0, 256, 256, KIND_BOX, 0, 0, 256, 256);
        send_pair(KIND_BOX, 0, 0, 256, 256, KIND_SPARE, 0, 0, 256, 256);
        send_pair(KIND_SPARE, 0, 0, 256, 256, KIND_SPARE, 0, 0, 256, 256);

        // Random pairs. Most are placed close to each other so that both outcomes are
        // common; some sit right on a decision edge, some on a box corner, and a tenth
        // are fully random so that every field bit toggles.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            ka = pick_kind();
            kb = pick_kind();
            xa = CB'($urandom());
            ya = CB'($urandom());
            wa = pick_size();
            ha = pick_size();
            wb = pick_size();
            hb = pick_size();
            style = $urandom_range(0, 9);
            case (style)
                0: begin
                    xb = CB'($urandom());
                    yb = CB'($urandom());
                    wa = (CB-1)'($urandom());
                    ha = (CB-1)'($urandom());
                    wb = (CB-1)'($urandom());
                    hb = (CB-1)'($urandom());
                end
                1, 2: begin
                    // Place b so that a single axis sits exactly on the edge between hit
                    // and miss, then move it by one step either way or not at all.
                    flip = 1'($urandom_range(0, 1));
                    if (ka == KIND_CIRCLE && kb == KIND_CIRCLE)
                        o = int'(wa) + int'(wb);
                    else if (ka == KIND_BOX && kb == KIND_BOX)
                        o = flip ? (int'(ha) + int'(hb)) / 2 : (int'(wa) + int'(wb)) / 2;
                    else if (ka == KIND_BOX && kb == KIND_CIRCLE)
                        o = $urandom_range(0, 1) ? (flip ? int'(ha) : int'(wa)) + int'(wb)
                                                 : -int'(wb);
                    else if (ka == KIND_CIRCLE && kb == KIND_BOX)
                        o = $urandom_range(0, 1) ? -((flip ? int'(hb) : int'(wb)) + int'(wa))
                                                 : int'(wa);
                    else
                        o = int'(wa);
                    if ((ka == kb) && $urandom_range(0, 1))
                        o = -o;
                    o = o + int'($urandom_range(0, 2)) - 1;
                    xb = flip ? xa : CB'(int'(xa) + o);
                    yb = flip ? CB'(int'(ya) + o) : ya;
                end
                3, 4: begin
                    // Circle center off a box corner on a scaled 3-4-5 triangle, with the
                    // radius on, just inside or just outside the corner distance.
                    m  = $urandom_range(1, 2000);
                    cx = $urandom_range(0, 1) ? int'(xa) + int'(wa) + 3*m : int'(xa) - 3*m;
                    cy = $urandom_range(0, 1) ? int'(ya) + int'(ha) + 4*m : int'(ya) - 4*m;
                    r  = 5*m + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(0, 1)) begin
                        ka = KIND_BOX;
                        kb = KIND_CIRCLE;
                        xb = CB'(cx);
                        yb = CB'(cy);
                        wb = (CB-1)'(r);
                    end else begin
                        ka = KIND_CIRCLE;
                        kb = KIND_BOX;
                        xb = xa;
                        yb = ya;
                        wb = wa;
                        hb = ha;
                        xa = CB'(cx);
                        ya = CB'(cy);
                        wa = (CB-1)'(r);
                    end
                end
                default: begin
                    span = int'(wa) + int'(wb) + int'(ha) + int'(hb) + 16;
                    xb = CB'(int'(xa) + int'($urandom_range(0, 2*span)) - span);
                    yb = CB'(int'(ya) + int'($urandom_range(0, 2*span)) - span);
                end
            endcase
            send_pair(ka, xa, ya, wa, ha, kb, xb, yb, wb, hb);
        end
        s_axis_tvalid = 1'b0;

        // Drain: wait for every predicted item, then keep the clock running to catch extras.
        while (results_out != pairs_in)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Run covered %0d collider pairs: directed edges, corners and extremes, then",
                 pairs_in);
        $display("random pairs of all kinds; %0d overlapped, input held off %0d cycles.",
                 overlaps_seen, held_off_cycles);
        if (fail_count == 0)
            $display("collider_pair_overlap_test_tb: PASS");
        else
            $display("collider_pair_overlap_test_tb: FAIL");
        $finish;
    end

endmodule
